/* rtl/core/lfe_pkg.sv */
// Package for the line item field extractor: widths, character codes, field
// numbers, word types and the fraction padding helper.
// No dependencies.
package lfe_pkg;

	localparam int FRAC_DIGITS = 2;
	localparam int KEY_WIDTH   = 32;
	localparam int QTY_WIDTH   = 16;
	localparam int PRICE_WIDTH = 40;
	localparam int MAX_FRAC    = 6;

	// accumulator*10 + digit needs four extra bits
	localparam int KEY_SUM_W   = KEY_WIDTH + 4;
	localparam int QTY_SUM_W   = QTY_WIDTH + 4;
	localparam int PRICE_SUM_W = PRICE_WIDTH + 4;

	localparam logic [7:0] DELIM = 8'h7C;
	localparam logic [7:0] POINT = 8'h2E;

	localparam logic [2:0] KEY_FIELD   = 3'd1;
	localparam logic [2:0] QTY_FIELD   = 3'd4;
	localparam logic [2:0] PRICE_FIELD = 3'd5;

	localparam logic [2:0] FRAC_LAST = 3'(FRAC_DIGITS);

	typedef logic [KEY_WIDTH-1:0]   key_t;
	typedef logic [QTY_WIDTH-1:0]   qty_t;
	typedef logic [PRICE_WIDTH-1:0] price_t;

	localparam key_t   KEY_MAX   = '1;
	localparam qty_t   QTY_MAX   = '1;
	localparam price_t PRICE_MAX = '1;

	localparam logic [63:0] PRICE_MAX64 = 64'(PRICE_MAX);

	localparam logic [63:0] POW10 [0:MAX_FRAC] = '{
		64'd1, 64'd10, 64'd100, 64'd1000, 64'd10000, 64'd100000, 64'd1000000
	};

	// largest price that can still be scaled by 10^k without overflow
	localparam logic [63:0] PAD_LIMIT [0:MAX_FRAC] = '{
		PRICE_MAX64 / 64'd1,
		PRICE_MAX64 / 64'd10,
		PRICE_MAX64 / 64'd100,
		PRICE_MAX64 / 64'd1000,
		PRICE_MAX64 / 64'd10000,
		PRICE_MAX64 / 64'd100000,
		PRICE_MAX64 / 64'd1000000
	};

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_SHORT  = 2'd1,
		ST_FORMAT = 2'd2
	} status_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       line_end;
	} in_word_t;

	typedef struct packed {
		key_t    part_key;
		qty_t    quantity;
		price_t  price_scaled;
		status_t status;
	} out_word_t;

	typedef struct packed {
		logic [2:0] field_idx;
		key_t       key_acc;
		qty_t       qty_acc;
		price_t     price_acc;
		logic [2:0] frac_count;
		logic       seen_point;
		logic       skipping;
		logic       format_error;
	} parse_state_t;

	// Scale price by 10^k, saturating. Returns {overflow, value}.
	function automatic logic [PRICE_WIDTH:0] pad_price(price_t p, logic [2:0] k);
		logic [63:0] wide;
		logic        ovf;
		price_t      r;
		wide = '0;
		ovf  = 1'b0;
		r    = p;
		for (int j = 0; j <= MAX_FRAC; j++) begin
			if (k == 3'(j)) begin
				if (64'(p) > PAD_LIMIT[j]) begin
					r   = PRICE_MAX;
					ovf = 1'b1;
				end else begin
					wide = 64'(p) * POW10[j];
					r    = PRICE_WIDTH'(wide);
				end
			end
		end
		return {ovf, r};
	endfunction

endpackage

/* rtl/core/lfe_step.sv */
// Next-state and result logic for one character of a delimited row.
// Depends on lfe_pkg.
module lfe_step (
	input  lfe_pkg::parse_state_t cur,
	input  lfe_pkg::in_word_t     word,
	output lfe_pkg::parse_state_t nxt,
	output logic                  emit,
	output lfe_pkg::out_word_t    res
);

	logic                          digit;
	logic [3:0]                    dval;
	logic [lfe_pkg::KEY_SUM_W-1:0]   key_sum;
	logic [lfe_pkg::QTY_SUM_W-1:0]   qty_sum;
	logic [lfe_pkg::PRICE_SUM_W-1:0] price_sum;
	logic                          key_ovf;
	logic                          qty_ovf;
	logic                          price_ovf;
	logic [lfe_pkg::PRICE_WIDTH:0] padded;
	logic                          record;

	assign digit = (word.ch >= 8'h30) && (word.ch <= 8'h39);
	assign dval  = digit ? word.ch[3:0] : 4'd0;

	assign key_sum = lfe_pkg::KEY_SUM_W'(cur.key_acc) * lfe_pkg::KEY_SUM_W'(10)
		+ lfe_pkg::KEY_SUM_W'(dval);
	assign qty_sum = lfe_pkg::QTY_SUM_W'(cur.qty_acc) * lfe_pkg::QTY_SUM_W'(10)
		+ lfe_pkg::QTY_SUM_W'(dval);
	assign price_sum = lfe_pkg::PRICE_SUM_W'(cur.price_acc) * lfe_pkg::PRICE_SUM_W'(10)
		+ lfe_pkg::PRICE_SUM_W'(dval);

	assign key_ovf   = key_sum[lfe_pkg::KEY_SUM_W-1:lfe_pkg::KEY_WIDTH] != '0;
	assign qty_ovf   = qty_sum[lfe_pkg::QTY_SUM_W-1:lfe_pkg::QTY_WIDTH] != '0;
	assign price_ovf = price_sum[lfe_pkg::PRICE_SUM_W-1:lfe_pkg::PRICE_WIDTH] != '0;

	// pad missing fraction digits before the record goes out
	assign padded = lfe_pkg::pad_price(cur.price_acc, lfe_pkg::FRAC_LAST - cur.frac_count);

	always_comb begin
		nxt    = cur;
		emit   = 1'b0;
		res    = '0;
		record = 1'b0;
		if (cur.skipping) begin
			if (word.line_end)
				nxt = '0;
		end else begin
			if (word.ch == lfe_pkg::DELIM) begin
				if (cur.field_idx == lfe_pkg::PRICE_FIELD) begin
					record           = 1'b1;
					emit             = 1'b1;
					res.part_key     = cur.key_acc;
					res.quantity     = cur.qty_acc;
					res.price_scaled = padded[lfe_pkg::PRICE_WIDTH-1:0];
					res.status       = (cur.format_error || padded[lfe_pkg::PRICE_WIDTH]) ?
						lfe_pkg::ST_FORMAT : lfe_pkg::ST_OK;
					nxt              = '0;
					nxt.skipping     = !word.line_end;
				end else begin
					nxt.field_idx = cur.field_idx + 3'd1;
				end
			end else begin
				case (cur.field_idx)
					lfe_pkg::KEY_FIELD: begin
						if (!digit) begin
							nxt.format_error = 1'b1;
						end else if (key_ovf) begin
							nxt.key_acc      = lfe_pkg::KEY_MAX;
							nxt.format_error = 1'b1;
						end else begin
							nxt.key_acc = key_sum[lfe_pkg::KEY_WIDTH-1:0];
						end
					end
					lfe_pkg::QTY_FIELD: begin
						if (!digit) begin
							nxt.format_error = 1'b1;
						end else if (qty_ovf) begin
							nxt.qty_acc      = lfe_pkg::QTY_MAX;
							nxt.format_error = 1'b1;
						end else begin
							nxt.qty_acc = qty_sum[lfe_pkg::QTY_WIDTH-1:0];
						end
					end
					lfe_pkg::PRICE_FIELD: begin
						if (word.ch == lfe_pkg::POINT) begin
							if (cur.seen_point)
								nxt.format_error = 1'b1;
							nxt.seen_point = 1'b1;
						end else if (!digit) begin
							nxt.format_error = 1'b1;
						end else if (!cur.seen_point ||
								cur.frac_count < lfe_pkg::FRAC_LAST) begin
							if (price_ovf) begin
								nxt.price_acc    = lfe_pkg::PRICE_MAX;
								nxt.format_error = 1'b1;
							end else begin
								nxt.price_acc = price_sum[lfe_pkg::PRICE_WIDTH-1:0];
							end
							if (cur.seen_point)
								nxt.frac_count = cur.frac_count + 3'd1;
						end
						// extra fraction digits are dropped
					end
					default: begin
					end
				endcase
			end
			// row ended before the sixth delimiter
			if (word.line_end && !record) begin
				emit       = 1'b1;
				res        = '0;
				res.status = lfe_pkg::ST_SHORT;
				nxt        = '0;
			end
		end
	end

endmodule

/* rtl/core/lineitem_field_extractor_core.sv */
// An accepted word is registered in item_s1; its result, if it makes one, is registered
// in result_q when the word advances, which a full, unread result register can hold off.
// Throughput: one character per cycle while the output is not stalled; the parse state
// loop is a single multiply-by-ten accumulate and compare per cycle.
// Reset (arst_n low): both pipeline valids and all parse state clear at once.
// Depends on lfe_pkg and lfe_step.
module lineitem_field_extractor_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_ready,
	input  lfe_pkg::in_word_t  item,
	output logic               result_valid,
	input  logic               result_ready,
	output lfe_pkg::out_word_t result
);

	lfe_pkg::in_word_t     item_s1;
	logic                  valid_s1;
	lfe_pkg::parse_state_t state_q;
	lfe_pkg::parse_state_t state_nxt;
	logic                  emit;
	lfe_pkg::out_word_t    res;
	lfe_pkg::out_word_t    result_q;
	logic                  result_valid_q;
	logic                  advance;

	lfe_step u_step (
		.cur  (state_q),
		.word (item_s1),
		.nxt  (state_nxt),
		.emit (emit),
		.res  (res)
	);

	// a word that makes no result never waits on the output side
	assign advance    = valid_s1 && (!emit || !result_valid_q || result_ready);
	assign item_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid)
			item_s1 <= item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (advance)
				state_q <= state_nxt;
			if (advance && emit)
				result_valid_q <= 1'b1;
			else if (result_ready)
				result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit)
			result_q <= res;
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule
